>>> rtl/core/bpfq_pkg.sv
package bpfq_pkg;

    localparam int POOL_SIZE_DEF  = 16;
    localparam int DESC_WIDTH_DEF = 32;

    // Fixed field widths of the request and response words.
    localparam int IDX_W     = 4;
    localparam int PAY_W     = 32;
    localparam int QCOUNT_W  = 5;
    localparam int STATUS_W  = 3;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ALLOC   = 2'd2,
        OP_RECYCLE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_RETRY  = 3'd1,
        ST_FAIL   = 3'd2,
        ST_QEMPTY = 3'd3,
        ST_REJECT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        IDX_ZERO = 2'd0,
        IDX_POP  = 2'd1,
        IDX_HELD = 2'd2
    } idx_sel_t;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [PAY_W-1:0] payload;
        logic             wait_flag;
        logic [IDX_W-1:0] buffer_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    result_index;
        logic [PAY_W-1:0]    result_payload;
        logic                queue_empty;
        logic [QCOUNT_W-1:0] queue_count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     take;
        logic     pop;
        logic     enq;
        logic     push;
        logic     deq;
        logic     fl_push;
        logic     load;
        status_t  code;
        idx_sel_t idx_sel;
        logic     pay_desc;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic wait_flag;
        logic clear_on_full;
        logic free_empty;
        logic free_full;
        logic q_empty;
        logic q_full;
        logic bidx_bad;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/bpfq_ctrl.sv
module bpfq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bpfq_pkg::dp_stat_t  stat,
    output bpfq_pkg::dp_cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_FLWAIT = 6'b000100,
        S_FLPUSH = 6'b001000,
        S_RESP   = 6'b010000,
        S_SPARE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.op)
                    bpfq_pkg::OP_WRITE:
                    begin
                        // A failed write with clear-on-full drains the queue first.
                        if (stat.free_empty && !stat.wait_flag && stat.clear_on_full &&
                            !stat.q_empty)
                        begin
                            state_next = S_FLWAIT;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_IDLE;
                            if (stat.free_empty)
                            begin
                                if (stat.wait_flag)
                                begin
                                    cmd.code = bpfq_pkg::ST_RETRY;
                                end
                                else
                                begin
                                    cmd.code = bpfq_pkg::ST_FAIL;
                                end
                            end
                            else if (stat.q_full)
                            begin
                                cmd.code = bpfq_pkg::ST_FAIL;
                            end
                            else
                            begin
                                cmd.pop     = 1'b1;
                                cmd.enq     = 1'b1;
                                cmd.idx_sel = bpfq_pkg::IDX_POP;
                            end
                        end
                    end
                    bpfq_pkg::OP_READ:
                    begin
                        if (!stat.q_empty)
                        begin
                            cmd.deq    = 1'b1;
                            state_next = S_RESP;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.load   = 1'b1;
                            cmd.code   = bpfq_pkg::ST_QEMPTY;
                            state_next = S_IDLE;
                        end
                    end
                    bpfq_pkg::OP_ALLOC:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_IDLE;
                            if (stat.free_empty)
                            begin
                                cmd.code = bpfq_pkg::ST_FAIL;
                            end
                            else
                            begin
                                cmd.pop     = 1'b1;
                                cmd.idx_sel = bpfq_pkg::IDX_POP;
                            end
                        end
                    end
                    bpfq_pkg::OP_RECYCLE:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_IDLE;
                            if (stat.bidx_bad || stat.free_full)
                            begin
                                cmd.code = bpfq_pkg::ST_REJECT;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FLWAIT:
            begin
                // The ring read at the current head settles during this cycle.
                if (stat.q_empty || stat.free_full)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_FLPUSH;
                end
            end
            S_FLPUSH:
            begin
                cmd.fl_push = 1'b1;
                state_next  = S_FLWAIT;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                    if (stat.op == bpfq_pkg::OP_READ)
                    begin
                        cmd.idx_sel  = bpfq_pkg::IDX_HELD;
                        cmd.pay_desc = 1'b1;
                    end
                    else
                    begin
                        cmd.code = bpfq_pkg::ST_FAIL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/bpfq_datapath.sv
module bpfq_datapath #(
    parameter int POOL_SIZE  = bpfq_pkg::POOL_SIZE_DEF,
    parameter int DESC_WIDTH = bpfq_pkg::DESC_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bpfq_pkg::req_t      req,
    output bpfq_pkg::rsp_t      rsp,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    input  bpfq_pkg::dp_cmd_t   cmd,
    output bpfq_pkg::dp_stat_t  stat
);

    localparam int PTR_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W  = $clog2(POOL_SIZE + 1);
    localparam int RIDX_W = bpfq_pkg::IDX_W;
    localparam int RPAY_W = bpfq_pkg::PAY_W;
    localparam int RCNT_W = bpfq_pkg::QCOUNT_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_SIZE);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(POOL_SIZE - 1);

    logic [PTR_W-1:0]      stack_mem [POOL_SIZE];
    logic [PTR_W-1:0]      ring_mem  [POOL_SIZE];
    logic [DESC_WIDTH-1:0] desc_mem  [POOL_SIZE];

    bpfq_pkg::req_t        req_reg;
    logic                  cof_reg;
    logic [CNT_W-1:0]      free_count_reg;
    logic [CNT_W-1:0]      free_count_next;
    logic [CNT_W-1:0]      mark_reg;
    logic [CNT_W-1:0]      mark_next;
    logic [PTR_W-1:0]      head_reg;
    logic [PTR_W-1:0]      head_next;
    logic [PTR_W-1:0]      tail_reg;
    logic [PTR_W-1:0]      tail_next;
    logic [CNT_W-1:0]      queued_reg;
    logic [CNT_W-1:0]      queued_next;
    logic [PTR_W-1:0]      stack_q_reg;
    logic [PTR_W-1:0]      stack_addr_reg;
    logic                  stack_virgin_reg;
    logic [PTR_W-1:0]      ring_q_reg;
    logic [DESC_WIDTH-1:0] desc_q_reg;
    logic [PTR_W-1:0]      held_idx_reg;
    bpfq_pkg::rsp_t        rsp_reg;
    bpfq_pkg::rsp_t        rsp_next;
    logic                  rsp_valid_reg;

    logic [CNT_W-1:0]      top_cnt;
    logic [PTR_W-1:0]      top_ptr;
    logic [PTR_W-1:0]      push_ptr;
    logic [PTR_W-1:0]      pop_val;
    logic                  stack_we;
    logic [PTR_W-1:0]      stack_wd;
    logic [PTR_W-1:0]      res_idx;

    assign top_cnt  = free_count_reg - CNT_W'(1);
    assign top_ptr  = top_cnt[PTR_W-1:0];
    assign push_ptr = free_count_reg[PTR_W-1:0];

    // Stack slots below the lowest fill level ever reached were never written;
    // for them the slot's own index is used as the value, as after reset.
    assign pop_val  = stack_virgin_reg ? stack_addr_reg : stack_q_reg;

    assign stack_we = cmd.push || cmd.fl_push;
    assign stack_wd = cmd.fl_push ? ring_q_reg : PTR_W'(req_reg.buffer_index);

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[push_ptr] <= stack_wd;
        end
        stack_q_reg      <= stack_mem[top_ptr];
        stack_addr_reg   <= top_ptr;
        stack_virgin_reg <= (top_cnt < mark_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            ring_mem[tail_reg] <= pop_val;
        end
        ring_q_reg <= ring_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            desc_mem[pop_val] <= DESC_WIDTH'(req_reg.payload);
        end
        if (cmd.deq)
        begin
            desc_q_reg   <= desc_mem[ring_q_reg];
            held_idx_reg <= ring_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg <= req;
        end
        if (cmd.load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        free_count_next = free_count_reg;
        if (cmd.pop)
        begin
            free_count_next = top_cnt;
        end
        else if (stack_we)
        begin
            free_count_next = free_count_reg + CNT_W'(1);
        end

        mark_next = mark_reg;
        if (cmd.pop && (top_cnt < mark_reg))
        begin
            mark_next = top_cnt;
        end

        head_next   = head_reg;
        queued_next = queued_reg;
        if (cmd.deq || cmd.fl_push)
        begin
            head_next   = (head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1);
            queued_next = queued_reg - CNT_W'(1);
        end
        else if (cmd.enq)
        begin
            queued_next = queued_reg + CNT_W'(1);
        end

        tail_next = tail_reg;
        if (cmd.enq)
        begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + PTR_W'(1);
        end
    end

    always_comb
    begin
        case (cmd.idx_sel)
            bpfq_pkg::IDX_POP:  res_idx = pop_val;
            bpfq_pkg::IDX_HELD: res_idx = held_idx_reg;
            default:            res_idx = '0;
        endcase
        rsp_next.status         = cmd.code;
        rsp_next.result_index   = RIDX_W'(res_idx);
        rsp_next.result_payload = cmd.pay_desc ? RPAY_W'(desc_q_reg) : '0;
        rsp_next.queue_empty    = (queued_next == '0);
        rsp_next.queue_count    = RCNT_W'(queued_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cof_reg        <= 1'b0;
            free_count_reg <= FULL_CNT;
            mark_reg       <= FULL_CNT;
            head_reg       <= '0;
            tail_reg       <= '0;
            queued_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cof_reg <= cfg_data;
            end
            free_count_reg <= free_count_next;
            mark_reg       <= mark_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            queued_reg     <= queued_next;
            if (cmd.load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        stat.op            = bpfq_pkg::op_t'(req_reg.opcode);
        stat.wait_flag     = req_reg.wait_flag;
        stat.clear_on_full = cof_reg;
        stat.free_empty    = (free_count_reg == '0);
        stat.free_full     = (free_count_reg == FULL_CNT);
        stat.q_empty       = (queued_reg == '0);
        stat.q_full        = (queued_reg == FULL_CNT);
        stat.bidx_bad      = (32'(req_reg.buffer_index) >= 32'(POOL_SIZE));
        stat.out_free      = !rsp_valid_reg || rsp_ready;
    end

endmodule

>>> rtl/core/buffer_pool_frame_queue_core.sv
// Buffer pool with a free stack and a frame queue.
// Requests arrive on req (req_valid/req_ready); each word carries an opcode
// (write, read oldest, allocate, recycle), a descriptor, a wait flag and a
// buffer index. Every request produces exactly one response word on rsp
// (rsp_valid/rsp_ready) with a status, the buffer index, the descriptor for
// reads, and the queue fill after the operation.
// The clear-on-full register is written through cfg_valid/cfg_data; the port
// is always ready and should only be written while the block is idle.
// Write, allocate, recycle and most failed operations load the response in
// the execute state; a successful read and a flush load it from the response
// state (the descriptor memory is read after the ring lookup). A flush after
// a failed write with clear-on-full set moves each buffer through a wait and
// a push state. One request is processed at a time; a new request is taken
// in idle, once the previous one has finished. The finished response
// sits in an output register, so the next request is accepted while it waits.
// When the receiver stalls, the next request completes its lookup and then
// holds until the output register is free.
// Reset leaves all buffers on the free stack, highest index on top, with an
// empty queue and clear-on-full off; no clearing pass is needed.
module buffer_pool_frame_queue_core #(
    parameter int POOL_SIZE  = bpfq_pkg::POOL_SIZE_DEF,
    parameter int DESC_WIDTH = bpfq_pkg::DESC_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bpfq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bpfq_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);

    bpfq_pkg::dp_cmd_t  cmd;
    bpfq_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bpfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpfq_datapath #(
        .POOL_SIZE  (POOL_SIZE),
        .DESC_WIDTH (DESC_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> rtl/core/bpfq_checker.sv
module bpfq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input bpfq_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input bpfq_pkg::rsp_t rsp
);

    // A response word holds until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed or dropped while stalled");

    // Requests are handled one at a time, so ready drops after each accepted word.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while the previous one was in progress");

    // The empty flag agrees with the queue count.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.queue_empty == (rsp.queue_count == '0)))
        else $error("queue_empty disagrees with queue_count");

    // A failed operation reports no buffer and no descriptor.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != bpfq_pkg::ST_OK) |->
            (rsp.result_index == '0) && (rsp.result_payload == '0))
        else $error("failed operation returned a buffer or descriptor");

    // Once reset has been applied at an edge, no response is presented.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("response valid during reset");

endmodule

bind buffer_pool_frame_queue_core bpfq_checker u_checker (.*);
